>>> rtl/gn2_pkg.sv
// ----------------------------------------------------------------------------
// gn2_pkg
// Shared constants, types and lookup functions for the 2-D gradient noise
// pipeline.
// ----------------------------------------------------------------------------
package gn2_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int INT_BITS      = 16;
    localparam int OUT_FRAC_BITS = 15;
    localparam int ANGLE_STEPS   = 360;

    // pipeline depth, stages numbered from 1 (input capture) to NSTAGE (output)
    localparam int NSTAGE = 19;

    localparam int IN_W   = 32;
    localparam int OUT_W  = 16;
    localparam int TRIG_W = 16;
    localparam int ANG_W  = 9;

    // hash constants
    localparam logic [63:0] HASH_MX = 64'h9E3779B185EBCA87;
    localparam logic [63:0] HASH_MY = 64'hC2B2AE3D27D4EB4F;
    localparam logic [63:0] HASH_F1 = 64'hFF51AFD7ED558CCD;
    localparam logic [63:0] HASH_F2 = 64'hC4CEB9FE1A85EC53;
    localparam int          MIX_SHIFT = 33;

    // corner coordinate product width: signed cell times 33-bit half word
    localparam int CM_W = INT_BITS + 33;

    // modulo 360: byte fold, then reciprocal multiply and one correction
    localparam int FOLD_W   = 19;
    localparam int REM_W    = 10;
    localparam int RECIP_SH = 27;
    localparam logic [FOLD_W-1:0] RECIP_M = FOLD_W'((2 ** RECIP_SH) / ANGLE_STEPS);
    localparam logic [8:0] BYTE_WEIGHT [8] = '{
        9'd1, 9'd256, 9'd16, 9'd136, 9'd256, 9'd16, 9'd136, 9'd256
    };

    // dot product and blend widths
    localparam int DX_W       = FRAC_BITS + 1;
    localparam int DOT_PROD_W = DX_W + TRIG_W;
    localparam int DOT_SUM_W  = DOT_PROD_W + 1;
    localparam int DOT_SH     = FRAC_BITS + 15 - OUT_FRAC_BITS;
    localparam int DOT_W      = DOT_SUM_W - DOT_SH;
    localparam int S_W        = FRAC_BITS + 1;
    localparam int L1_W       = DOT_W + 1;
    localparam int LP1_W      = L1_W + S_W + 1;
    localparam int L2_W       = L1_W + 1;
    localparam int LP2_W      = L2_W + S_W + 1;

    // fade widths
    localparam int Q_W = FRAC_BITS + 5;

    typedef logic [NSTAGE:1]      t_stage_en;
    typedef logic [3:0][63:0]     t_hash4;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_v;
        logic signed [TRIG_W-1:0] sin_v;
    } t_grad;

    typedef t_grad [3:0] t_grad4;

    // first quadrant of sine in Q1.15, one entry per degree
    localparam logic [14:0] QSINE [91] = '{
        15'd0,     15'd572,   15'd1144,  15'd1715,  15'd2286,  15'd2856,  15'd3425,
        15'd3993,  15'd4560,  15'd5126,  15'd5690,  15'd6252,  15'd6813,  15'd7371,
        15'd7927,  15'd8481,  15'd9032,  15'd9580,  15'd10126, 15'd10668, 15'd11207,
        15'd11743, 15'd12275, 15'd12803, 15'd13328, 15'd13848, 15'd14365, 15'd14876,
        15'd15384, 15'd15886, 15'd16384, 15'd16877, 15'd17364, 15'd17847, 15'd18324,
        15'd18795, 15'd19261, 15'd19720, 15'd20174, 15'd20622, 15'd21063, 15'd21498,
        15'd21926, 15'd22348, 15'd22763, 15'd23170, 15'd23571, 15'd23965, 15'd24351,
        15'd24730, 15'd25102, 15'd25466, 15'd25822, 15'd26170, 15'd26510, 15'd26842,
        15'd27166, 15'd27482, 15'd27789, 15'd28088, 15'd28378, 15'd28660, 15'd28932,
        15'd29197, 15'd29452, 15'd29698, 15'd29935, 15'd30163, 15'd30382, 15'd30592,
        15'd30792, 15'd30983, 15'd31164, 15'd31336, 15'd31499, 15'd31651, 15'd31795,
        15'd31928, 15'd32052, 15'd32166, 15'd32270, 15'd32365, 15'd32449, 15'd32524,
        15'd32588, 15'd32643, 15'd32688, 15'd32723, 15'd32748, 15'd32763, 15'd32767
    };

    function automatic logic signed [TRIG_W-1:0] sine_deg(input logic [ANG_W-1:0] d);
        logic [ANG_W-1:0] idx;
        logic             neg;
        logic signed [TRIG_W-1:0] mag;
        idx = d;
        neg = 1'b0;
        if (d < ANG_W'(90)) begin
            idx = d;
        end else if (d < ANG_W'(180)) begin
            idx = ANG_W'(180) - d;
        end else if (d < ANG_W'(270)) begin
            idx = d - ANG_W'(180);
            neg = 1'b1;
        end else begin
            idx = ANG_W'(360) - d;
            neg = 1'b1;
        end
        mag = $signed({1'b0, QSINE[idx[6:0]]});
        return neg ? -mag : mag;
    endfunction

    function automatic logic signed [TRIG_W-1:0] cosine_deg(input logic [ANG_W-1:0] d);
        logic [ANG_W:0] t;
        t = {1'b0, d} + (ANG_W+1)'(90);
        if (t >= (ANG_W+1)'(ANGLE_STEPS)) begin
            t = t - (ANG_W+1)'(ANGLE_STEPS);
        end
        return sine_deg(t[ANG_W-1:0]);
    endfunction

endpackage

>>> rtl/gradient_noise_2d_unit.sv
// ----------------------------------------------------------------------------
// gradient_noise_2d_unit
// Two-dimensional gradient noise, one signed Q1.15 value per Q16.16 point.
// ----------------------------------------------------------------------------
// usage
//   s-channel: one transaction per point, tdata = {point_y, point_x}.
//   m-channel: one transaction per point, tdata = noise_value, in order.
//   i_cfg_wr_en / i_cfg_wr_data write the 64-bit seed; write it only while
//   no point is in flight.
// throughput
//   one point per cycle while the output accepts results.
//   the pipeline depth is set by the hash path: two 64-bit finalizer multiplies,
//   each split into 32-bit partial products and a register stage for the sum,
//   then the modulo-360 reciprocal multiply and the table lookup.
// stalls
//   every stage holds a valid bit; a stage loads whenever it is empty or the
//   next one moves, so bubbles close up and the input keeps accepting while
//   the result register waits. o_s_tready drops only when all stages are full.
// reset
//   synchronous, clears all valid bits and the seed to zero.
// ----------------------------------------------------------------------------
module gradient_noise_2d_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [63:0] i_cfg_wr_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [31:0] point_x, [63:32] point_y
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata    // [15:0] noise_value
);

    localparam int N = gn2_pkg::NSTAGE;

    logic [63:0]               r_seed;
    logic [N:1]                r_valid;
    gn2_pkg::t_stage_en        w_en;

    logic signed [gn2_pkg::INT_BITS-1:0]  r_cell_x, r_cell_y;
    logic [gn2_pkg::FRAC_BITS-1:0]        r_fx, r_fy;
    logic signed [gn2_pkg::IN_W-1:0]      w_px, w_py;
    logic signed [gn2_pkg::IN_W-1:0]      w_flx, w_fly;

    gn2_pkg::t_hash4                      w_hash;
    gn2_pkg::t_grad4                      w_grad;
    logic [gn2_pkg::FRAC_BITS-1:0]        w_fx13, w_fy13;
    logic [gn2_pkg::S_W-1:0]              w_sx15, w_sy15;
    logic [gn2_pkg::OUT_W-1:0]            w_noise;

    // a stage may load when empty or when the stage after it moves
    always_comb begin
        w_en[N] = !r_valid[N] || i_m_tready;
        for (int k = N - 1; k >= 1; k--) begin
            w_en[k] = !r_valid[k] || w_en[k+1];
        end
    end

    assign o_s_tready = w_en[1];
    assign o_m_tvalid = r_valid[N];
    assign o_m_tdata  = w_noise;

    assign w_px  = $signed(i_s_tdata[31:0]);
    assign w_py  = $signed(i_s_tdata[63:32]);
    assign w_flx = w_px >>> gn2_pkg::FRAC_BITS;
    assign w_fly = w_py >>> gn2_pkg::FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed  <= '0;
            r_valid <= '0;
        end else begin
            if (i_cfg_wr_en) r_seed <= i_cfg_wr_data;
            if (w_en[1]) r_valid[1] <= i_s_tvalid;
            for (int k = 2; k <= N; k++) begin
                if (w_en[k]) r_valid[k] <= r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_cell_x <= w_flx[gn2_pkg::INT_BITS-1:0];
            r_cell_y <= w_fly[gn2_pkg::INT_BITS-1:0];
            r_fx     <= w_px[gn2_pkg::FRAC_BITS-1:0];
            r_fy     <= w_py[gn2_pkg::FRAC_BITS-1:0];
        end
    end

    gn2_hash u_hash (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_seed   (r_seed),
        .i_cell_x (r_cell_x),
        .i_cell_y (r_cell_y),
        .o_hash   (w_hash)
    );

    gn2_angle u_angle (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_hash (w_hash),
        .o_grad (w_grad)
    );

    gn2_fade u_fade (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_fx  (r_fx),
        .i_fy  (r_fy),
        .o_fx  (w_fx13),
        .o_fy  (w_fy13),
        .o_sx  (w_sx15),
        .o_sy  (w_sy15)
    );

    gn2_blend u_blend (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_grad  (w_grad),
        .i_fx    (w_fx13),
        .i_fy    (w_fy13),
        .i_sx    (w_sx15),
        .i_sy    (w_sy15),
        .o_noise (w_noise)
    );

`ifndef SYNTHESIS
    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // input back-pressure only when every stage holds a point
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (&r_valid) && !i_m_tready)
        else $error("input stalled with a free stage");

    // an accepted transaction lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> r_valid[1])
        else $error("accepted point lost at entry");

    // a blocked point in the middle of the pipe is kept
    a_mid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[10] && !w_en[11] |=> r_valid[10])
        else $error("stalled point dropped");
`endif

endmodule

>>> rtl/gn2_hash.sv
// ----------------------------------------------------------------------------
// gn2_hash
// Corner hash for the four cell corners, stages 2 to 9: coordinate products,
// seed mix and two finalizer multiplies split into 32-bit partial products.
// ----------------------------------------------------------------------------
module gn2_hash (
    input  logic                                 i_clk,
    input  gn2_pkg::t_stage_en                   i_en,
    input  logic [63:0]                          i_seed,
    input  logic signed [gn2_pkg::INT_BITS-1:0]  i_cell_x,
    input  logic signed [gn2_pkg::INT_BITS-1:0]  i_cell_y,
    output gn2_pkg::t_hash4                      o_hash
);

    logic signed [gn2_pkg::CM_W-1:0] r_pxl, r_pxh, r_pyl, r_pyh;
    logic signed [gn2_pkg::CM_W-1:0] n_pxl, n_pxh, n_pyl, n_pyh;
    logic [63:0] r_px3, r_py3, n_px3, n_py3;
    logic [63:0] r_px4 [2];
    logic [63:0] r_py4 [2];
    logic [63:0] r_h5 [4];
    logic [63:0] n_h5 [4];
    logic [63:0] r_ll6 [4];
    logic [31:0] r_lh6 [4];
    logic [31:0] r_hl6 [4];
    logic [63:0] n_ll6 [4];
    logic [31:0] n_lh6 [4];
    logic [31:0] n_hl6 [4];
    logic [63:0] r_h7 [4];
    logic [63:0] n_h7 [4];
    logic [63:0] r_ll8 [4];
    logic [31:0] r_lh8 [4];
    logic [31:0] r_hl8 [4];
    logic [63:0] n_ll8 [4];
    logic [31:0] n_lh8 [4];
    logic [31:0] n_hl8 [4];
    logic [63:0] r_h9 [4];
    logic [63:0] n_h9 [4];

    always_comb begin
        n_pxl = i_cell_x * $signed({1'b0, gn2_pkg::HASH_MX[31:0]});
        n_pxh = i_cell_x * $signed({1'b0, gn2_pkg::HASH_MX[63:32]});
        n_pyl = i_cell_y * $signed({1'b0, gn2_pkg::HASH_MY[31:0]});
        n_pyh = i_cell_y * $signed({1'b0, gn2_pkg::HASH_MY[63:32]});
        n_px3 = 64'(r_pxl) + {r_pxh[31:0], 32'h0};
        n_py3 = 64'(r_pyl) + {r_pyh[31:0], 32'h0};
    end

    always_comb begin
        logic [63:0] h;
        logic [63:0] m;
        for (int k = 0; k < 4; k++) begin
            // corner order: (x0,y0) (x0,y0+1) (x0+1,y0) (x0+1,y0+1)
            h = i_seed ^ r_px4[k[1]] ^ r_py4[k[0]];
            n_h5[k] = h ^ (h >> gn2_pkg::MIX_SHIFT);

            n_ll6[k] = r_h5[k][31:0] * gn2_pkg::HASH_F1[31:0];
            n_lh6[k] = r_h5[k][31:0] * gn2_pkg::HASH_F1[63:32];
            n_hl6[k] = r_h5[k][63:32] * gn2_pkg::HASH_F1[31:0];
            m = r_ll6[k] + {r_lh6[k] + r_hl6[k], 32'h0};
            n_h7[k] = m ^ (m >> gn2_pkg::MIX_SHIFT);

            n_ll8[k] = r_h7[k][31:0] * gn2_pkg::HASH_F2[31:0];
            n_lh8[k] = r_h7[k][31:0] * gn2_pkg::HASH_F2[63:32];
            n_hl8[k] = r_h7[k][63:32] * gn2_pkg::HASH_F2[31:0];
            m = r_ll8[k] + {r_lh8[k] + r_hl8[k], 32'h0};
            n_h9[k] = m ^ (m >> gn2_pkg::MIX_SHIFT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_pxl <= n_pxl;
            r_pxh <= n_pxh;
            r_pyl <= n_pyl;
            r_pyh <= n_pyh;
        end
        if (i_en[3]) begin
            r_px3 <= n_px3;
            r_py3 <= n_py3;
        end
        if (i_en[4]) begin
            // (c+1)*M is c*M + M modulo 2^64
            r_px4[0] <= r_px3;
            r_px4[1] <= r_px3 + gn2_pkg::HASH_MX;
            r_py4[0] <= r_py3;
            r_py4[1] <= r_py3 + gn2_pkg::HASH_MY;
        end
        for (int k = 0; k < 4; k++) begin
            if (i_en[5]) r_h5[k] <= n_h5[k];
            if (i_en[6]) begin
                r_ll6[k] <= n_ll6[k];
                r_lh6[k] <= n_lh6[k];
                r_hl6[k] <= n_hl6[k];
            end
            if (i_en[7]) r_h7[k] <= n_h7[k];
            if (i_en[8]) begin
                r_ll8[k] <= n_ll8[k];
                r_lh8[k] <= n_lh8[k];
                r_hl8[k] <= n_hl8[k];
            end
            if (i_en[9]) r_h9[k] <= n_h9[k];
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            o_hash[k] = r_h9[k];
        end
    end

endmodule

>>> rtl/gn2_angle.sv
// ----------------------------------------------------------------------------
// gn2_angle
// Hash modulo 360 and gradient lookup, stages 10 to 13.
// ----------------------------------------------------------------------------
module gn2_angle (
    input  logic               i_clk,
    input  gn2_pkg::t_stage_en i_en,
    input  gn2_pkg::t_hash4    i_hash,
    output gn2_pkg::t_grad4    o_grad
);

    localparam int QP_W = 2 * gn2_pkg::FOLD_W;

    logic [gn2_pkg::FOLD_W-1:0] r_fold10 [4];
    logic [gn2_pkg::FOLD_W-1:0] n_fold10 [4];
    logic [gn2_pkg::FOLD_W-1:0] r_fold11 [4];
    logic [QP_W-1:0]            r_qp11 [4];
    logic [QP_W-1:0]            n_qp11 [4];
    logic [gn2_pkg::REM_W-1:0]  r_rem12 [4];
    logic [gn2_pkg::REM_W-1:0]  n_rem12 [4];
    gn2_pkg::t_grad4            r_grad13;
    gn2_pkg::t_grad4            n_grad13;

    always_comb begin
        logic [gn2_pkg::FOLD_W-1:0]          acc;
        logic [gn2_pkg::FOLD_W-1:0]          rem;
        logic [gn2_pkg::REM_W-1:0]           r;
        logic [gn2_pkg::ANG_W-1:0]           ang;
        for (int k = 0; k < 4; k++) begin
            // each byte weighted by 2^(8i) mod 360
            acc = '0;
            for (int i = 0; i < 8; i++) begin
                acc = acc + gn2_pkg::FOLD_W'(i_hash[k][8*i +: 8])
                          * gn2_pkg::FOLD_W'(gn2_pkg::BYTE_WEIGHT[i]);
            end
            n_fold10[k] = acc;

            n_qp11[k] = QP_W'(r_fold10[k]) * QP_W'(gn2_pkg::RECIP_M);

            // quotient may be one short, remainder stays below 720
            rem = r_fold11[k]
                - gn2_pkg::FOLD_W'(r_qp11[k][QP_W-1:gn2_pkg::RECIP_SH])
                * gn2_pkg::FOLD_W'(gn2_pkg::ANGLE_STEPS);
            n_rem12[k] = rem[gn2_pkg::REM_W-1:0];

            r = r_rem12[k];
            if (r >= gn2_pkg::REM_W'(gn2_pkg::ANGLE_STEPS)) begin
                r = r - gn2_pkg::REM_W'(gn2_pkg::ANGLE_STEPS);
            end
            ang = r[gn2_pkg::ANG_W-1:0];
            n_grad13[k].cos_v = gn2_pkg::cosine_deg(ang);
            n_grad13[k].sin_v = gn2_pkg::sine_deg(ang);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            if (i_en[10]) r_fold10[k] <= n_fold10[k];
            if (i_en[11]) begin
                r_fold11[k] <= r_fold10[k];
                r_qp11[k]   <= n_qp11[k];
            end
            if (i_en[12]) r_rem12[k] <= n_rem12[k];
        end
        if (i_en[13]) r_grad13 <= n_grad13;
    end

    assign o_grad = r_grad13;

endmodule

>>> rtl/gn2_fade.sv
// ----------------------------------------------------------------------------
// gn2_fade
// Quintic fade of both fractions, stages 2 to 8, with delay lines that
// align the fractions and the fade weights to the blend stages.
// ----------------------------------------------------------------------------
module gn2_fade (
    input  logic                          i_clk,
    input  gn2_pkg::t_stage_en            i_en,
    input  logic [gn2_pkg::FRAC_BITS-1:0] i_fx,
    input  logic [gn2_pkg::FRAC_BITS-1:0] i_fy,
    output logic [gn2_pkg::FRAC_BITS-1:0] o_fx,
    output logic [gn2_pkg::FRAC_BITS-1:0] o_fy,
    output logic [gn2_pkg::S_W-1:0]       o_sx,
    output logic [gn2_pkg::S_W-1:0]       o_sy
);

    localparam int F    = gn2_pkg::FRAC_BITS;
    localparam int UU_W = 2 * F;
    localparam int U2_W = F + 1;
    localparam int T6_W = 2 * F + 3;
    localparam int UQ_W = U2_W + gn2_pkg::Q_W;

    localparam logic [UU_W-1:0] HALF_UU = UU_W'(2 ** (F - 1));
    localparam logic [T6_W-1:0] HALF_T6 = T6_W'(2 ** (F - 1));
    localparam logic [UQ_W-1:0] HALF_UQ = UQ_W'(2 ** (F - 1));
    localparam logic [gn2_pkg::Q_W-1:0] TEN_ONE = gn2_pkg::Q_W'(10 * (2 ** F));

    logic [F-1:0]            w_u [2];
    logic [F-1:0]            r_fd [2][2:13];
    logic [UU_W-1:0]         r_uu2 [2];
    logic [F+3:0]            r_u15 [2];
    logic [U2_W-1:0]         r_u23 [2];
    logic [gn2_pkg::Q_W-1:0] r_q3 [2];
    logic [U2_W+F-1:0]       r_u2u4 [2];
    logic [gn2_pkg::Q_W-1:0] r_q4 [2];
    logic [U2_W-1:0]         r_u35 [2];
    logic [gn2_pkg::Q_W-1:0] r_q5 [2];
    logic [UQ_W-1:0]         r_u3q6 [2];
    logic [gn2_pkg::S_W-1:0] r_s [2][8:15];

    logic [UU_W-1:0]         n_uu2 [2];
    logic [F+3:0]            n_u15 [2];
    logic [U2_W-1:0]         n_u23 [2];
    logic [gn2_pkg::Q_W-1:0] n_q3 [2];
    logic [U2_W+F-1:0]       n_u2u4 [2];
    logic [U2_W-1:0]         n_u35 [2];
    logic [UQ_W-1:0]         n_u3q6 [2];
    logic [gn2_pkg::S_W-1:0] n_s7 [2];

    assign w_u[0] = i_fx;
    assign w_u[1] = i_fy;

    always_comb begin
        logic [T6_W-1:0]         t6;
        logic [UU_W:0]           r2;
        logic [U2_W+F:0]         r3;
        logic [UQ_W-1:0]         rs;
        logic [gn2_pkg::Q_W-1:0] q;
        for (int l = 0; l < 2; l++) begin
            n_uu2[l] = UU_W'(r_fd[l][2]) * UU_W'(r_fd[l][2]);
            n_u15[l] = (F+4)'(r_fd[l][2]) * (F+4)'(15);

            r2 = {1'b0, r_uu2[l]} + {1'b0, HALF_UU};
            n_u23[l] = r2[UU_W:F];
            t6 = (T6_W'(r_uu2[l]) << 2) + (T6_W'(r_uu2[l]) << 1) + HALF_T6;
            q = TEN_ONE + gn2_pkg::Q_W'(t6[T6_W-1:F]);
            n_q3[l] = q - gn2_pkg::Q_W'(r_u15[l]);

            n_u2u4[l] = (U2_W+F)'(r_u23[l]) * (U2_W+F)'(r_fd[l][4]);

            r3 = {1'b0, r_u2u4[l]} + (U2_W+F+1)'(2 ** (F - 1));
            n_u35[l] = r3[U2_W+F-1:F];

            n_u3q6[l] = UQ_W'(r_u35[l]) * UQ_W'(r_q5[l]);

            rs = r_u3q6[l] + HALF_UQ;
            n_s7[l] = rs[F+gn2_pkg::S_W-1:F];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 2; l++) begin
            if (i_en[2]) r_fd[l][2] <= w_u[l];
            for (int k = 3; k <= 13; k++) begin
                if (i_en[k]) r_fd[l][k] <= r_fd[l][k-1];
            end
            if (i_en[3]) begin
                r_uu2[l] <= n_uu2[l];
                r_u15[l] <= n_u15[l];
            end
            if (i_en[4]) begin
                r_u23[l] <= n_u23[l];
                r_q3[l]  <= n_q3[l];
            end
            if (i_en[5]) begin
                r_u2u4[l] <= n_u2u4[l];
                r_q4[l]   <= r_q3[l];
            end
            if (i_en[6]) begin
                r_u35[l] <= n_u35[l];
                r_q5[l]  <= r_q4[l];
            end
            if (i_en[7]) begin
                r_u3q6[l] <= n_u3q6[l];
            end
            if (i_en[8]) r_s[l][8] <= n_s7[l];
            for (int k = 9; k <= 15; k++) begin
                if (i_en[k]) r_s[l][k] <= r_s[l][k-1];
            end
        end
    end

    assign o_fx = r_fd[0][13];
    assign o_fy = r_fd[1][13];
    assign o_sx = r_s[0][15];
    assign o_sy = r_s[1][15];

endmodule

>>> rtl/gn2_blend.sv
// ----------------------------------------------------------------------------
// gn2_blend
// Corner dot products, bilinear blend and output saturation, stages 14 to 19.
// ----------------------------------------------------------------------------
module gn2_blend (
    input  logic                          i_clk,
    input  gn2_pkg::t_stage_en            i_en,
    input  gn2_pkg::t_grad4               i_grad,
    input  logic [gn2_pkg::FRAC_BITS-1:0] i_fx,
    input  logic [gn2_pkg::FRAC_BITS-1:0] i_fy,
    input  logic [gn2_pkg::S_W-1:0]       i_sx,
    input  logic [gn2_pkg::S_W-1:0]       i_sy,
    output logic [gn2_pkg::OUT_W-1:0]     o_noise
);

    localparam int F = gn2_pkg::FRAC_BITS;
    localparam logic signed [gn2_pkg::DOT_SUM_W-1:0] DOT_HALF =
        gn2_pkg::DOT_SUM_W'(2 ** (gn2_pkg::DOT_SH - 1));
    localparam logic signed [gn2_pkg::LP1_W-1:0] LP1_HALF = gn2_pkg::LP1_W'(2 ** (F - 1));
    localparam logic signed [gn2_pkg::LP2_W-1:0] LP2_HALF = gn2_pkg::LP2_W'(2 ** (F - 1));
    localparam logic signed [gn2_pkg::L2_W-1:0]  SAT_HI   = gn2_pkg::L2_W'(32767);
    localparam logic signed [gn2_pkg::L2_W-1:0]  SAT_LO   = -gn2_pkg::L2_W'(32768);

    logic signed [gn2_pkg::DOT_PROD_W-1:0] r_pc14 [4];
    logic signed [gn2_pkg::DOT_PROD_W-1:0] r_ps14 [4];
    logic signed [gn2_pkg::DOT_PROD_W-1:0] n_pc14 [4];
    logic signed [gn2_pkg::DOT_PROD_W-1:0] n_ps14 [4];
    logic signed [gn2_pkg::DOT_W-1:0]      r_dot15 [4];
    logic signed [gn2_pkg::DOT_W-1:0]      n_dot15 [4];
    logic signed [gn2_pkg::LP1_W-1:0]      r_lp16 [2];
    logic signed [gn2_pkg::LP1_W-1:0]      n_lp16 [2];
    logic signed [gn2_pkg::DOT_W-1:0]      r_a16 [2];
    logic [gn2_pkg::S_W-1:0]               r_sy16, r_sy17;
    logic signed [gn2_pkg::L1_W-1:0]       r_l17 [2];
    logic signed [gn2_pkg::L1_W-1:0]       n_l17 [2];
    logic signed [gn2_pkg::LP2_W-1:0]      r_lp18, n_lp18;
    logic signed [gn2_pkg::L1_W-1:0]       r_a18;
    logic [gn2_pkg::OUT_W-1:0]             r_out19, n_out19;

    always_comb begin
        logic signed [gn2_pkg::DX_W-1:0]      dx;
        logic signed [gn2_pkg::DX_W-1:0]      dy;
        logic signed [gn2_pkg::DOT_SUM_W-1:0] sm;
        logic signed [gn2_pkg::DOT_SUM_W-1:0] sh;
        for (int k = 0; k < 4; k++) begin
            // offset to the far corner is the fraction minus one
            dx = $signed({k[1] ? 1'b1 : 1'b0, i_fx});
            dy = $signed({k[0] ? 1'b1 : 1'b0, i_fy});
            n_pc14[k] = dx * i_grad[k].cos_v;
            n_ps14[k] = dy * i_grad[k].sin_v;

            sm = gn2_pkg::DOT_SUM_W'(r_pc14[k]) + gn2_pkg::DOT_SUM_W'(r_ps14[k]) + DOT_HALF;
            sh = sm >>> gn2_pkg::DOT_SH;
            n_dot15[k] = sh[gn2_pkg::DOT_W-1:0];
        end
    end

    always_comb begin
        logic signed [gn2_pkg::L1_W-1:0]  diff1;
        logic signed [gn2_pkg::LP1_W-1:0] p1;
        logic signed [gn2_pkg::L2_W-1:0]  diff2;
        logic signed [gn2_pkg::LP2_W-1:0] p2;
        logic signed [gn2_pkg::L2_W-1:0]  v;
        for (int j = 0; j < 2; j++) begin
            // j = 0 blends the y0 pair, j = 1 the y0+1 pair
            diff1 = gn2_pkg::L1_W'(r_dot15[j+2]) - gn2_pkg::L1_W'(r_dot15[j]);
            n_lp16[j] = diff1 * $signed({1'b0, i_sx});
            p1 = (r_lp16[j] + LP1_HALF) >>> F;
            n_l17[j] = gn2_pkg::L1_W'(r_a16[j]) + p1[gn2_pkg::L1_W-1:0];
        end
        diff2 = gn2_pkg::L2_W'(r_l17[1]) - gn2_pkg::L2_W'(r_l17[0]);
        n_lp18 = diff2 * $signed({1'b0, r_sy17});
        p2 = (r_lp18 + LP2_HALF) >>> F;
        v = gn2_pkg::L2_W'(r_a18) + p2[gn2_pkg::L2_W-1:0];
        if (v > SAT_HI) begin
            n_out19 = SAT_HI[gn2_pkg::OUT_W-1:0];
        end else if (v < SAT_LO) begin
            n_out19 = SAT_LO[gn2_pkg::OUT_W-1:0];
        end else begin
            n_out19 = v[gn2_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            if (i_en[14]) begin
                r_pc14[k] <= n_pc14[k];
                r_ps14[k] <= n_ps14[k];
            end
            if (i_en[15]) r_dot15[k] <= n_dot15[k];
        end
        for (int j = 0; j < 2; j++) begin
            if (i_en[16]) begin
                r_lp16[j] <= n_lp16[j];
                r_a16[j]  <= r_dot15[j];
            end
            if (i_en[17]) r_l17[j] <= n_l17[j];
        end
        if (i_en[16]) r_sy16 <= i_sy;
        if (i_en[17]) r_sy17 <= r_sy16;
        if (i_en[18]) begin
            r_lp18 <= n_lp18;
            r_a18  <= r_l17[0];
        end
        if (i_en[19]) r_out19 <= n_out19;
    end

    assign o_noise = r_out19;

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for gradient_noise_2d_unit: directed and random points
// under several seeds, random gaps and back-pressure on both streams, every
// result compared in order against a bit-accurate noise predictor.
// ----------------------------------------------------------------------------
module tb;

    localparam int N_RANDOM    = 1330;
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [63:0] i_cfg_wr_data;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [63:0] i_s_tdata;   // [31:0] point_x, [63:32] point_y
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;   // [15:0] noise_value

    gradient_noise_2d_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata)
    );

    typedef struct {
        logic [31:0] px;
        logic [31:0] py;
        logic        known;   // expected value typed in
        logic [15:0] noise;
    } t_point_row;

    logic [63:0] seed_q;
    logic [15:0] noise_expected_q[$];
    int          n_errors;
    int          n_checked;
    int          n_sent;
    longint      cycle_cnt = 0;

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout at %0t", $time);
            $display("tb: FAIL");
            $finish;
        end
    end

    // ---------------- predictor ----------------
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint trig_deg(int d);
        int q;
        int r;
        longint m;
        q = (d / 90) & 3;
        r = d % 90;
        m = (q & 1) ? gn2_pkg::QSINE[90 - r] : gn2_pkg::QSINE[r];
        return (q & 2) ? -m : m;
    endfunction

    function automatic logic [63:0] mix_hash(longint cx, longint cy);
        logic [63:0] h;
        h = seed_q ^ (64'(cx) * gn2_pkg::HASH_MX) ^ (64'(cy) * gn2_pkg::HASH_MY);
        h = h ^ (h >> 33);
        h = h * gn2_pkg::HASH_F1;
        h = h ^ (h >> 33);
        h = h * gn2_pkg::HASH_F2;
        h = h ^ (h >> 33);
        return h;
    endfunction

    function automatic longint gradient_dot(longint cx, longint cy, longint dx, longint dy);
        int ang;
        longint d;
        ang = int'(mix_hash(cx, cy) % 64'd360);
        d = dx * trig_deg((ang + 90) % 360) + dy * trig_deg(ang);
        return round_shift(d, gn2_pkg::FRAC_BITS + 15 - gn2_pkg::OUT_FRAC_BITS);
    endfunction

    function automatic longint fade_curve(longint u);
        longint u2;
        longint u3;
        longint q;
        u2 = round_shift(u * u, gn2_pkg::FRAC_BITS);
        u3 = round_shift(u2 * u, gn2_pkg::FRAC_BITS);
        q = 10 * (longint'(1) << gn2_pkg::FRAC_BITS)
            + round_shift(6 * u * u, gn2_pkg::FRAC_BITS) - 15 * u;
        return round_shift(u3 * q, gn2_pkg::FRAC_BITS);
    endfunction

    function automatic longint mix_lerp(longint a, longint b, longint s);
        return a + round_shift((b - a) * s, gn2_pkg::FRAC_BITS);
    endfunction

    function automatic logic [15:0] predict_noise(logic [31:0] px, logic [31:0] py);
        longint one;
        longint x0;
        longint y0;
        longint fx;
        longint fy;
        longint sx;
        longint sy;
        longint v;
        one = longint'(1) << gn2_pkg::FRAC_BITS;
        x0 = longint'($signed(gn2_pkg::INT_BITS'(
                 floor_shift(longint'($signed(px)), gn2_pkg::FRAC_BITS))));
        y0 = longint'($signed(gn2_pkg::INT_BITS'(
                 floor_shift(longint'($signed(py)), gn2_pkg::FRAC_BITS))));
        fx = longint'(px[gn2_pkg::FRAC_BITS-1:0]);
        fy = longint'(py[gn2_pkg::FRAC_BITS-1:0]);
        sx = fade_curve(fx);
        sy = fade_curve(fy);
        v = mix_lerp(mix_lerp(gradient_dot(x0, y0, fx, fy),
                              gradient_dot(x0 + 1, y0, fx - one, fy), sx),
                     mix_lerp(gradient_dot(x0, y0 + 1, fx, fy - one),
                              gradient_dot(x0 + 1, y0 + 1, fx - one, fy - one), sx), sy);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    // ---------------- driving ----------------
    // tvalid stays high into the next call, so back-to-back points need no gap
    task automatic send_point(logic [31:0] px, logic [31:0] py, logic known, logic [15:0] nv);
        int gap;
        logic [15:0] pred;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pred = predict_noise(px, py);
        if (known && pred !== nv) begin
            $display("%0t table row mismatch: expected %h predicted %h", $time, nv, pred);
            n_errors++;
        end
        noise_expected_q.push_back(known ? nv : pred);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {py, px};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_and_settle();
        i_s_tvalid <= 1'b0;
        while (noise_expected_q.size() != 0) @(negedge i_clk);
        repeat (gn2_pkg::NSTAGE + 4) @(negedge i_clk);
    endtask

    task automatic write_seed(logic [63:0] v);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        seed_q = v;
    endtask

    // ---------------- result check ----------------
    int stall_left;
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (noise_expected_q.size() == 0) begin
                $display("%0t unexpected result: expected none actual %h", $time, o_m_tdata);
                n_errors++;
            end else begin
                if (o_m_tdata !== noise_expected_q[0]) begin
                    $display("%0t noise mismatch: expected %h actual %h",
                             $time, noise_expected_q[0], o_m_tdata);
                    n_errors++;
                end
                void'(noise_expected_q.pop_front());
                n_checked++;
            end
        end
    end

    // sink stalls, with calm stretches
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
            if (o_m_tvalid && (cycle_cnt % 2000) > 400)
                stall_left <= $urandom_range(0, 5);
        end
    end

    t_point_row dir_rows[] = '{
        '{32'h0000_0000, 32'h0000_0000, 1'b1, 16'h0000},   // lattice point gives zero
        '{32'h0001_0000, 32'h0003_0000, 1'b1, 16'h0000},
        '{32'h8000_0000, 32'h8000_0000, 1'b1, 16'h0000},
        '{32'h7FFF_0000, 32'hFFFF_0000, 1'b1, 16'h0000},
        '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 16'h0},      // top cell corner
        '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 16'h0},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 16'h0},
        '{32'h0000_8000, 32'h0000_8000, 1'b0, 16'h0},
        '{32'h0000_0001, 32'h0000_FFFF, 1'b0, 16'h0},
        '{32'h8000_FFFF, 32'h0000_0001, 1'b0, 16'h0},
        '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 16'h0},
        '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 16'h0},
        '{32'h7FFF_8000, 32'h8000_8000, 1'b0, 16'h0},
        '{32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 16'h0}
    };

    logic [63:0] seeds[] = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0001};

    initial begin
        logic [31:0] px;
        logic [31:0] py;
        int base;
        n_errors = 0; n_checked = 0; n_sent = 0;
        stall_left = 0; seed_q = 64'h0;
        i_rst_n = 1'b0; i_cfg_wr_en = 1'b0; i_cfg_wr_data = 64'h0;
        i_s_tvalid = 1'b0; i_s_tdata = 64'h0; i_m_tready = 1'b1;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[r])
            send_point(dir_rows[r].px, dir_rows[r].py, dir_rows[r].known, dir_rows[r].noise);
        drain_and_settle();

        for (int ph = 0; ph < 4; ph++) begin
            if (ph < 3) write_seed(seeds[ph]);
            else write_seed({$urandom, $urandom});
            for (int k = 0; k < N_RANDOM / 4; k++) begin
                if ($urandom_range(0, 2) == 0) begin
                    px = $urandom; py = $urandom;
                end else begin
                    // walk a small neighborhood so corners get shared
                    base = $urandom_range(0, 7) - 4;
                    px = {16'(base + $urandom_range(0, 3)), 16'($urandom)};
                    py = {16'(base + $urandom_range(0, 3)), 16'($urandom)};
                end
                send_point(px, py, 1'b0, 16'h0);
                if (k == 100) begin
                    // hold off until the pipeline is empty
                    i_s_tvalid <= 1'b0;
                    do @(negedge i_clk); while (noise_expected_q.size() != 0);
                end
            end
            drain_and_settle();
        end

        $display("sent %0d points over 4 seed settings, %0d results checked",
                 n_sent, n_checked);
        $display("directed extremes, top cells, lattice points and random grid walks");
        if (n_errors == 0 && noise_expected_q.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule
